/* rtl/hole_fit_allocator_defines.svh */
// assertion macros for the hole fit allocator
`ifndef HOLE_FIT_ALLOCATOR_DEFINES_SVH
`define HOLE_FIT_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define HFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define HFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/hfa_pkg.sv */
// shared constants, codes and types of the hole fit allocator
package hfa_pkg;

    localparam int HOLES_DEF     = 16;
    localparam int SIZE_BITS_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 4;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int HCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_COUNT = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_WRITE,
        S_RESTORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic orig_we;
        logic rem_we;
    } t_tbl_ctl;

endpackage

/* rtl/hfa_channels.sv */
// channel interfaces: command input, result output, configuration write
interface hfa_in_if;
    logic                        valid;
    logic                        ready;
    logic [hfa_pkg::CMD_W-1:0]   command;
    logic [hfa_pkg::IDX_W-1:0]   hole_index;
    logic [hfa_pkg::SIZE_W-1:0]  size;
    modport source (output valid, command, hole_index, size, input ready);
    modport sink   (input valid, command, hole_index, size, output ready);
endinterface

interface hfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [hfa_pkg::STATUS_W-1:0]  status;
    logic [hfa_pkg::IDX_W-1:0]     chosen_hole;
    logic [hfa_pkg::SIZE_W-1:0]    remaining_after;
    modport source (output valid, status, chosen_hole, remaining_after, input ready);
    modport sink   (input valid, status, chosen_hole, remaining_after, output ready);
endinterface

interface hfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hfa_pkg::CFG_IDX_W-1:0]   index;
    logic [hfa_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hfa_table.sv */
// hole size tables: original and remaining sizes with registered read
module hfa_table #(
    parameter int HOLES     = hfa_pkg::HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF,
    parameter int ADR_W     = (HOLES > 1) ? $clog2(HOLES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hfa_pkg::t_tbl_ctl    i_ctl,
    input  logic [ADR_W-1:0]     i_rd_addr,
    input  logic [ADR_W-1:0]     i_wr_addr,
    input  logic [SIZE_BITS-1:0] i_orig_wd,
    input  logic [SIZE_BITS-1:0] i_rem_wd,
    output logic [SIZE_BITS-1:0] o_rd_orig,
    output logic [SIZE_BITS-1:0] o_rd_rem
);

    logic [SIZE_BITS-1:0] mem_orig [HOLES];
    logic [SIZE_BITS-1:0] mem_rem  [HOLES];
    logic [HOLES-1:0]     r_vld_orig;
    logic [HOLES-1:0]     r_vld_rem;
    logic [SIZE_BITS-1:0] r_rd_orig;
    logic [SIZE_BITS-1:0] r_rd_rem;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_orig <= '0;
            r_vld_rem  <= '0;
        end else begin
            if (i_ctl.orig_we) begin
                r_vld_orig[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rem_we) begin
                r_vld_rem[i_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.orig_we) begin
            mem_orig[i_wr_addr] <= i_orig_wd;
        end
        if (i_ctl.rem_we) begin
            mem_rem[i_wr_addr] <= i_rem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_orig <= r_vld_orig[i_rd_addr] ? mem_orig[i_rd_addr] : '0;
            r_rd_rem  <= r_vld_rem[i_rd_addr]  ? mem_rem[i_rd_addr]  : '0;
        end
    end

    assign o_rd_orig = r_rd_orig;
    assign o_rd_rem  = r_rd_rem;

endmodule

/* rtl/hfa_pick.sv */
// shared compare and subtract unit for the hole search
module hfa_pick #(
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
    input  logic [hfa_pkg::MODE_W-1:0] i_mode,
    input  logic                       i_found,
    input  logic [SIZE_BITS-1:0]       i_rem,
    input  logic [SIZE_BITS-1:0]       i_req,
    input  logic [SIZE_BITS-1:0]       i_best_rem,
    output logic                       o_better,
    output logic [SIZE_BITS-1:0]       o_diff
);

    logic fits;
    logic tighter;
    logic looser;

    always_comb begin
        fits    = (i_rem >= i_req);
        tighter = (i_mode == hfa_pkg::MODE_BEST)  && (i_rem < i_best_rem);
        looser  = (i_mode == hfa_pkg::MODE_WORST) && (i_rem > i_best_rem);
        // first fit and the unused mode keep the first hit
        o_better = fits && (!i_found || tighter || looser);
        o_diff   = i_best_rem - i_req;
    end

endmodule

/* rtl/hfa_seq.sv */
// command sequencer: load, scan over the table, write back, restore sweep
module hfa_seq #(
    parameter int HOLES     = hfa_pkg::HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF,
    parameter int ADR_W     = (HOLES > 1) ? $clog2(HOLES) : 1,
    parameter int CNT_W     = $clog2(HOLES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [hfa_pkg::CMD_W-1:0]      i_cmd,
    input  logic [hfa_pkg::IDX_W-1:0]      i_idx,
    input  logic [hfa_pkg::SIZE_W-1:0]     i_size,
    input  logic [hfa_pkg::MODE_W-1:0]     i_fit_mode,
    input  logic [hfa_pkg::HCNT_W-1:0]     i_hole_count,
    output hfa_pkg::t_tbl_ctl              o_tbl_ctl,
    output logic [ADR_W-1:0]               o_rd_addr,
    output logic [ADR_W-1:0]               o_wr_addr,
    output logic [SIZE_BITS-1:0]           o_orig_wd,
    output logic [SIZE_BITS-1:0]           o_rem_wd,
    input  logic [SIZE_BITS-1:0]           i_rd_orig,
    input  logic [SIZE_BITS-1:0]           i_rd_rem,
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output logic [hfa_pkg::STATUS_W-1:0]   o_status,
    output logic [hfa_pkg::IDX_W-1:0]      o_chosen,
    output logic [hfa_pkg::SIZE_W-1:0]     o_remain
);

    hfa_pkg::t_state r_state, n_state;

    logic [hfa_pkg::IDX_W-1:0]    r_idx,     n_idx;
    logic [SIZE_BITS-1:0]         r_req,     n_req;
    logic [CNT_W-1:0]             r_ptr,     n_ptr;
    logic [CNT_W-1:0]             r_lim,     n_lim;
    logic                         r_cmp_vld, n_cmp_vld;
    logic [ADR_W-1:0]             r_cmp_adr, n_cmp_adr;
    logic                         r_found,   n_found;
    logic [ADR_W-1:0]             r_best,    n_best;
    logic [SIZE_BITS-1:0]         r_best_rem, n_best_rem;
    logic [hfa_pkg::STATUS_W-1:0] r_status,  n_status;
    logic [hfa_pkg::IDX_W-1:0]    r_chosen,  n_chosen;
    logic [hfa_pkg::SIZE_W-1:0]   r_remain,  n_remain;

    logic                 accept;
    logic                 issue;
    logic                 idx_ok;
    logic                 better;
    logic [SIZE_BITS-1:0] diff;
    logic [CNT_W-1:0]     lim_now;

    hfa_pick #(
        .SIZE_BITS (SIZE_BITS)
    ) u_pick (
        .i_mode     (i_fit_mode),
        .i_found    (r_found),
        .i_rem      (i_rd_rem),
        .i_req      (r_req),
        .i_best_rem (r_best_rem),
        .o_better   (better),
        .o_diff     (diff)
    );

    always_comb begin
        accept = (r_state == hfa_pkg::S_IDLE) && i_in_valid;
        idx_ok = ({{(32 - hfa_pkg::IDX_W){1'b0}}, r_idx} < 32'(HOLES));
        if ({{(32 - hfa_pkg::HCNT_W){1'b0}}, i_hole_count} > 32'(HOLES)) begin
            lim_now = CNT_W'(HOLES);
        end else begin
            lim_now = CNT_W'(i_hole_count);
        end
        case (r_state)
            hfa_pkg::S_SCAN:    issue = (r_ptr < r_lim);
            hfa_pkg::S_RESTORE: issue = (r_ptr < CNT_W'(HOLES));
            default:            issue = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hfa_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        hfa_pkg::CMD_LOAD:    n_state = hfa_pkg::S_LOAD;
                        hfa_pkg::CMD_ALLOC:   n_state = hfa_pkg::S_SCAN;
                        hfa_pkg::CMD_RESTORE: n_state = hfa_pkg::S_RESTORE;
                        default:              n_state = hfa_pkg::S_DONE;
                    endcase
                end
            end
            hfa_pkg::S_LOAD:    n_state = hfa_pkg::S_DONE;
            hfa_pkg::S_SCAN: begin
                if (!issue && !r_cmp_vld) begin
                    n_state = hfa_pkg::S_WRITE;
                end
            end
            hfa_pkg::S_WRITE:   n_state = hfa_pkg::S_DONE;
            hfa_pkg::S_RESTORE: begin
                if (!issue && !r_cmp_vld) begin
                    n_state = hfa_pkg::S_DONE;
                end
            end
            hfa_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = hfa_pkg::S_IDLE;
                end
            end
            default:            n_state = hfa_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx      = r_idx;
        n_req      = r_req;
        n_ptr      = r_ptr;
        n_lim      = r_lim;
        n_cmp_vld  = 1'b0;
        n_cmp_adr  = r_ptr[ADR_W-1:0];
        n_found    = r_found;
        n_best     = r_best;
        n_best_rem = r_best_rem;
        n_status   = r_status;
        n_chosen   = r_chosen;
        n_remain   = r_remain;

        o_tbl_ctl  = '0;
        o_rd_addr  = r_ptr[ADR_W-1:0];
        o_wr_addr  = r_cmp_adr;
        o_orig_wd  = r_req;
        o_rem_wd   = i_rd_orig;

        case (r_state)
            hfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx    = i_idx;
                    n_req    = SIZE_BITS'(i_size);
                    n_ptr    = '0;
                    n_lim    = lim_now;
                    n_found  = 1'b0;
                    n_best   = '0;
                    n_status = hfa_pkg::STAT_DONE;
                    n_chosen = '0;
                    n_remain = '0;
                end
            end
            hfa_pkg::S_LOAD: begin
                o_wr_addr = ADR_W'(r_idx);
                o_rem_wd  = r_req;
                if (idx_ok) begin
                    o_tbl_ctl.orig_we = 1'b1;
                    o_tbl_ctl.rem_we  = 1'b1;
                    n_remain          = hfa_pkg::SIZE_W'(r_req);
                end
            end
            hfa_pkg::S_SCAN: begin
                o_tbl_ctl.rd_en = issue;
                n_cmp_vld       = issue;
                if (issue) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
                if (r_cmp_vld && better) begin
                    n_found    = 1'b1;
                    n_best     = r_cmp_adr;
                    n_best_rem = i_rd_rem;
                end
            end
            hfa_pkg::S_WRITE: begin
                o_wr_addr = r_best;
                o_rem_wd  = diff;
                if (r_found) begin
                    o_tbl_ctl.rem_we = 1'b1;
                    n_status         = hfa_pkg::STAT_ALLOC;
                    n_chosen         = hfa_pkg::IDX_W'(r_best);
                    n_remain         = hfa_pkg::SIZE_W'(diff);
                end else begin
                    n_status         = hfa_pkg::STAT_NOFIT;
                end
            end
            hfa_pkg::S_RESTORE: begin
                o_tbl_ctl.rd_en  = issue;
                n_cmp_vld        = issue;
                o_tbl_ctl.rem_we = r_cmp_vld;
                if (issue) begin
                    n_ptr = r_ptr + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        o_in_ready  = (r_state == hfa_pkg::S_IDLE);
        o_res_valid = (r_state == hfa_pkg::S_DONE);
        o_status    = r_status;
        o_chosen    = r_chosen;
        o_remain    = r_remain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hfa_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_req      <= n_req;
        r_ptr      <= n_ptr;
        r_lim      <= n_lim;
        r_cmp_adr  <= n_cmp_adr;
        r_best     <= n_best;
        r_best_rem <= n_best_rem;
        r_status   <= n_status;
        r_chosen   <= n_chosen;
        r_remain   <= n_remain;
    end

endmodule

/* rtl/hole_fit_allocator.sv */
// top level of the hole fit allocator: configuration, sequencer, tables, result register
//
//   channel   direction  handshake            payload
//   i_in      input      valid / ready        command, hole_index, size
//   o_out     output     valid / ready        status, chosen_hole, remaining_after
//   i_cfg     input      valid / ready        index, data (fit_mode, hole_count)
//
// restore reads back every one of the HOLES entries
// allocate scans min(hole_count, HOLES) holes, none with no hole in use:
// one table read per hole through one read port, then the last compare
// the next command is taken once the result sits in the output register
// configuration writes are always accepted; reset clears every hole size to zero
`include "hole_fit_allocator_defines.svh"

module hole_fit_allocator #(
    parameter int HOLES     = hfa_pkg::HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hfa_in_if.sink       i_in,
    hfa_out_if.source    o_out,
    hfa_cfg_if.sink      i_cfg
);

    localparam int ADR_W = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W = $clog2(HOLES + 1);

    logic [hfa_pkg::MODE_W-1:0]   r_fit_mode;
    logic [hfa_pkg::HCNT_W-1:0]   r_hole_count;

    logic                         r_out_vld;
    logic [hfa_pkg::STATUS_W-1:0] r_out_status;
    logic [hfa_pkg::IDX_W-1:0]    r_out_chosen;
    logic [hfa_pkg::SIZE_W-1:0]   r_out_remain;

    hfa_pkg::t_tbl_ctl            tbl_ctl;
    logic [ADR_W-1:0]             rd_addr;
    logic [ADR_W-1:0]             wr_addr;
    logic [SIZE_BITS-1:0]         orig_wd;
    logic [SIZE_BITS-1:0]         rem_wd;
    logic [SIZE_BITS-1:0]         rd_orig;
    logic [SIZE_BITS-1:0]         rd_rem;
    logic                         res_valid;
    logic                         res_take;
    logic [hfa_pkg::STATUS_W-1:0] res_status;
    logic [hfa_pkg::IDX_W-1:0]    res_chosen;
    logic [hfa_pkg::SIZE_W-1:0]   res_remain;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= '0;
            r_hole_count <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hfa_pkg::CFG_FIT_MODE:   r_fit_mode   <= i_cfg.data[hfa_pkg::MODE_W-1:0];
                hfa_pkg::CFG_HOLE_COUNT: r_hole_count <= i_cfg.data[hfa_pkg::HCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hfa_seq #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS),
        .ADR_W     (ADR_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_cmd        (i_in.command),
        .i_idx        (i_in.hole_index),
        .i_size       (i_in.size),
        .i_fit_mode   (r_fit_mode),
        .i_hole_count (r_hole_count),
        .o_tbl_ctl    (tbl_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_orig_wd    (orig_wd),
        .o_rem_wd     (rem_wd),
        .i_rd_orig    (rd_orig),
        .i_rd_rem     (rd_rem),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_status     (res_status),
        .o_chosen     (res_chosen),
        .o_remain     (res_remain)
    );

    hfa_table #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS),
        .ADR_W     (ADR_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_orig_wd (orig_wd),
        .i_rem_wd  (rem_wd),
        .o_rd_orig (rd_orig),
        .o_rd_rem  (rd_rem)
    );

    // result register
    assign res_take = res_valid && (!r_out_vld || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_status <= res_status;
            r_out_chosen <= res_chosen;
            r_out_remain <= res_remain;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.status          = r_out_status;
    assign o_out.chosen_hole     = r_out_chosen;
    assign o_out.remaining_after = r_out_remain;

    `HFA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready |=> !i_in.ready, "command accepted while busy")
    `HFA_ASSERT(a_no_pick_without_alloc, i_clk, i_rst_n, o_out.valid && (o_out.status != hfa_pkg::STAT_ALLOC) |-> (o_out.chosen_hole == '0), "hole reported without allocation")
    `HFA_ASSERT(a_result_after_take, i_clk, i_rst_n, res_take |=> o_out.valid, "result lost on the way to the output register")

endmodule

/* bench/hfa_result_checker.sv */
// checker for the hole fit allocator: mirrors the hole tables and scores every result
module hfa_result_checker
    import hfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hfa_in_if    in_ch,
    hfa_out_if   out_ch,
    hfa_cfg_if   cfg_ch,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_placed,
    output int   o_unplaced
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    hole;
        logic [SIZE_W-1:0]   remain;
    } hole_result_t;

    logic [SIZE_W-1:0] original_size  [HOLES_DEF];
    logic [SIZE_W-1:0] remaining_size [HOLES_DEF];
    logic [MODE_W-1:0] fit_mode;
    logic [HCNT_W-1:0] hole_count;
    hole_result_t      predicted_results [$];
    int                mismatches = 0;
    int                placed     = 0;
    int                unplaced   = 0;

    function automatic hole_result_t run_command(input logic [CMD_W-1:0]  cmd,
                                                 input logic [IDX_W-1:0]  idx,
                                                 input logic [SIZE_W-1:0] req);
        hole_result_t res;
        int           limit;
        int           pick;
        bit           found;
        res        = '0;
        res.status = STAT_DONE;
        case (cmd)
            CMD_LOAD: begin
                if (int'(idx) < HOLES_DEF) begin
                    original_size[idx]  = req;
                    remaining_size[idx] = req;
                    res.remain          = req;
                end
            end
            CMD_ALLOC: begin
                limit = (hole_count > HOLES_DEF) ? HOLES_DEF : int'(hole_count);
                found = 1'b0;
                pick  = 0;
                for (int i = 0; i < limit; i++) begin
                    if (remaining_size[i] >= req) begin
                        if (!found) begin
                            pick  = i;
                            found = 1'b1;
                        end else if (fit_mode == MODE_BEST &&
                                     remaining_size[i] < remaining_size[pick]) begin
                            pick = i;
                        end else if (fit_mode == MODE_WORST &&
                                     remaining_size[i] > remaining_size[pick]) begin
                            pick = i;
                        end
                    end
                end
                if (found) begin
                    remaining_size[pick] = remaining_size[pick] - req;
                    res.status           = STAT_ALLOC;
                    res.hole             = IDX_W'(pick);
                    res.remain           = remaining_size[pick];
                end else begin
                    res.status = STAT_NOFIT;
                end
            end
            CMD_RESTORE: begin
                for (int i = 0; i < HOLES_DEF; i++)
                    remaining_size[i] = original_size[i];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t  %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        hole_result_t want;
        if (!i_rst_n) begin
            fit_mode   = MODE_FIRST;
            hole_count = '0;
            for (int i = 0; i < HOLES_DEF; i++) begin
                original_size[i]  = '0;
                remaining_size[i] = '0;
            end
            predicted_results.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == CFG_FIT_MODE)
                    fit_mode = cfg_ch.data[MODE_W-1:0];
                else
                    hole_count = cfg_ch.data[HCNT_W-1:0];
            end
            if (in_ch.valid && in_ch.ready)
                predicted_results.push_back(run_command(in_ch.command, in_ch.hole_index,
                                                        in_ch.size));
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t  unexpected result: status %0d hole %0d remaining %0d",
                             $time, out_ch.status, out_ch.chosen_hole, out_ch.remaining_after);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    flag_field("status", want.status, out_ch.status);
                    flag_field("chosen_hole", want.hole, out_ch.chosen_hole);
                    flag_field("remaining_after", want.remain, out_ch.remaining_after);
                    if (want.status == STAT_ALLOC)
                        placed++;
                    else if (want.status == STAT_NOFIT)
                        unplaced++;
                end
            end
        end
        o_pending    <= predicted_results.size();
        o_mismatches <= mismatches;
        o_placed     <= placed;
        o_unplaced   <= unplaced;
    end

endmodule

/* bench/hole_fit_allocator_tb.sv */
// testbench top of the hole fit allocator: clock, reset, traffic phases and verdict
module hole_fit_allocator_tb;
    import hfa_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;
    localparam int                QUIET_LIMIT   = 5000;
    localparam int                SETTLE_CYCLES = HOLES_DEF + 8;
    localparam int                PHASE_ITEMS   = 385;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    int                idle_pct;
    int                stall_pct;
    int                quiet_cycles = 0;
    int                commands_sent = 0;
    int                config_writes = 0;
    int                mismatches;
    int                pending;
    int                placed;
    int                unplaced;
    logic [SIZE_W-1:0] loaded_size [HOLES_DEF];

    hfa_in_if  in_ch();
    hfa_out_if out_ch();
    hfa_cfg_if cfg_ch();

    hole_fit_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hfa_result_checker tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_placed     (placed),
        .o_unplaced   (unplaced)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t  watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic [CMD_W-1:0]  cmd,
                        input logic [IDX_W-1:0]  idx,
                        input logic [SIZE_W-1:0] sz);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.hole_index <= idx;
        in_ch.size       <= sz;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (cmd == CMD_LOAD)
            loaded_size[idx] = sz;
        commands_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mode_word,
                             input logic [CFG_DATA_W-1:0] count_word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_FIT_MODE;
        cfg_ch.data  <= mode_word;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.index <= CFG_HOLE_COUNT;
        cfg_ch.data  <= count_word;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        config_writes += 2;
    endtask

    function automatic logic [SIZE_W-1:0] hole_size();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2, 3:    return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(2000));
        endcase
    endfunction

    // mostly requests no larger than the loaded size of a random hole, so many of them fit
    function automatic logic [SIZE_W-1:0] request_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return SIZE_W'($urandom);
            3:       return SIZE_W'($urandom_range(15));
            default: return SIZE_W'($urandom_range(int'(loaded_size[$urandom_range(HOLES_DEF-1)])));
        endcase
    endfunction

    task automatic run_phase(input int idle, input int stall);
        int                target;
        int                count_word;
        int                loads;
        int                ops;
        int                roll;
        logic [SIZE_W-1:0] last;
        target    = commands_sent + PHASE_ITEMS;
        idle_pct  = idle;
        stall_pct <= stall;
        while (commands_sent < target) begin
            drain();
            case ($urandom_range(7))
                0:       count_word = 0;
                1:       count_word = HOLES_DEF;
                2:       count_word = 31;
                3:       count_word = 1;
                4:       count_word = $urandom_range(30, HOLES_DEF + 1);
                default: count_word = $urandom_range(HOLES_DEF, 2);
            endcase
            configure(CFG_DATA_W'($urandom), CFG_DATA_W'(count_word));
            loads = $urandom_range(HOLES_DEF, 1);
            last  = '0;
            // an occasional repeated size sets up ties
            for (int h = 0; h < loads; h++) begin
                if ($urandom_range(6) != 0)
                    last = hole_size();
                send(CMD_LOAD, IDX_W'(h), last);
            end
            ops = $urandom_range(30, 10);
            repeat (ops) begin
                roll = $urandom_range(99);
                if (roll < 80)
                    send(CMD_ALLOC, IDX_W'($urandom), request_size());
                else if (roll < 88)
                    send(CMD_LOAD, IDX_W'($urandom), hole_size());
                else if (roll < 96)
                    send(CMD_RESTORE, IDX_W'($urandom), SIZE_W'($urandom));
                else
                    send(CMD_UNUSED, IDX_W'($urandom), SIZE_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_LOAD;
        in_ch.hole_index <= '0;
        in_ch.size       <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_FIT_MODE;
        cfg_ch.data      <= '0;
        idle_pct         = 0;
        stall_pct        <= 0;
        foreach (loaded_size[h])
            loaded_size[h] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no hole in use
        send(CMD_ALLOC, '0, '0);
        send(CMD_LOAD, '0, 16'd100);
        send(CMD_ALLOC, 4'hf, '0);
        drain();
        configure({3'b111, MODE_FIRST}, 5'd4);
        send(CMD_LOAD, 4'd1, 16'hffff);
        send(CMD_LOAD, 4'd2, 16'd50);
        send(CMD_LOAD, 4'd3, 16'd50);
        send(CMD_LOAD, 4'd15, '0);
        send(CMD_ALLOC, '0, '0);
        send(CMD_ALLOC, '0, 16'd60);
        send(CMD_ALLOC, '0, 16'hffff);
        send(CMD_ALLOC, '0, 16'd400);
        send(CMD_UNUSED, 4'hf, 16'hffff);
        send(CMD_RESTORE, 4'hf, 16'hffff);
        drain();
        configure({3'b000, MODE_BEST}, 5'd4);
        send(CMD_ALLOC, '0, 16'd50);
        send(CMD_ALLOC, '0, 16'd1);
        drain();
        configure({3'b000, MODE_WORST}, 5'd4);
        send(CMD_ALLOC, '0, 16'd1);
        send(CMD_ALLOC, '0, 16'hffff);
        drain();
        configure({3'b111, MODE_SPARE}, 5'd31);
        send(CMD_RESTORE, '0, '0);
        send(CMD_LOAD, 4'd15, 16'hffff);
        send(CMD_ALLOC, '0, 16'hffff);
        send(CMD_ALLOC, '0, 16'hffff);
        send(CMD_ALLOC, '0, 16'd1);
        drain();
        configure(5'd0, 5'd0);
        send(CMD_ALLOC, '0, '0);

        run_phase(0, 0);
        run_phase(80, 0);
        run_phase(0, 80);
        run_phase(26, 26);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d commands and %0d register writes over four traffic phases",
                 commands_sent, config_writes);
        $display("allocation requests placed %0d, refused for lack of space %0d",
                 placed, unplaced);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hfa_pkg.sv
rtl/hfa_channels.sv
rtl/hfa_table.sv
rtl/hfa_pick.sv
rtl/hfa_seq.sv
rtl/hole_fit_allocator.sv
bench/hfa_result_checker.sv
bench/hole_fit_allocator_tb.sv
